@@ hw/rtl/hdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_pkg
// Shared types and constants of the hop-distance roulette next-hop block.
// ----------------------------------------------------------------------------
package hdr_pkg;

	localparam int MAX_NODES_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int RANDOM_BITS_DEF = 16;
	localparam logic [4:0] NODE_COUNT_RST = 5'd16;

	localparam logic [1:0] MODE_WRITE   = 2'd0;
	localparam logic [1:0] MODE_REBUILD = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;
	localparam logic [1:0] MODE_NOP     = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  link_from;
		logic [3:0]  link_to;
		logic        link_present;
		logic [15:0] link_weight;
		logic [3:0]  current_node;
		logic [3:0]  source_node;
		logic [3:0]  dest_node;
		logic [15:0] random_draw;
	} req_t;

	typedef struct packed {
		logic [3:0] next_hop;
		logic       has_candidate;
		logic       direct_hop;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RCLR,
		ST_RINIT,
		ST_RSCAN,
		ST_RWR,
		ST_QRD,
		ST_QCHK,
		ST_S1I,
		ST_S1C,
		ST_MUL,
		ST_S2I,
		ST_S2C,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/hop_distance_roulette_next_hop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hop_distance_roulette_next_hop
// Link table, breadth-first hop-distance table and roulette next-hop pick.
// ----------------------------------------------------------------------------
// One item at a time; req_stall stays high while an item is at work. A link
// write or a no-op goes straight to the result; a query first reads the direct
// link and the hop distances and ends there if it finds a direct hop or names
// a node out of range; any other query makes two passes over the nodes, each
// node read through the registered weight and hop memories, with a shift-add
// multiplier between the passes that takes one random bit a cycle; a rebuild
// resets the hop memory, then for every source runs a set-up step and for
// every breadth-first level a scan (one node per cycle through the shared
// frontier unit) and then one hop-memory write per cycle. A result that is
// still stalled holds the next one back. After reset a clearing pass over both
// memories runs before the first item is taken; configuration writes are taken
// at any time. A result waits in an output register.
module hop_distance_roulette_next_hop #(
	parameter int MAX_NODES   = hdr_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = hdr_pkg::WEIGHT_BITS_DEF,
	parameter int RANDOM_BITS = hdr_pkg::RANDOM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  hdr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output hdr_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [4:0]    cfg_data
);
	import hdr_pkg::*;

	localparam int NB  = $clog2(MAX_NODES);
	localparam int AW  = 2 * NB;
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int HB  = $clog2(2 * MAX_NODES);
	localparam int SW  = WEIGHT_BITS + NB;
	localparam int PW  = SW + RANDOM_BITS;
	localparam int RCW = $clog2(RANDOM_BITS);
	localparam logic [HB-1:0] HOP_UNREACH = HB'(2 * MAX_NODES - 1);

	state_t state_q, state_d;

	logic [4:0]             node_count_q;
	logic [MAX_NODES-1:0]   link_map_q [MAX_NODES];
	req_t                   req_q;
	rsp_t                   res_q, rsp_q;
	logic                   rsp_valid_q;
	logic [AW-1:0]          clr_q;
	logic [CW-1:0]          i_q, s_q;
	logic [HB-1:0]          lvl_q, cd_q, cs_q;
	logic [MAX_NODES-1:0]   seen_q, front_q, nxt_q;
	logic [SW-1:0]          sum_q, run_q;
	logic [PW-1:0]          acc_q;
	logic [RCW-1:0]         cnt_q;
	logic [NB-1:0]          first_q;
	logic                   found_q;

	// memories and their ports
	logic [WEIGHT_BITS-1:0] w_mem [2**AW];
	logic [HB-1:0]          h_mem [2**AW];
	logic                   w_we, h_we;
	logic [AW-1:0]          w_wa, w_ra, h_wa, h_ra0, h_ra1;
	logic [WEIGHT_BITS-1:0] w_wd, w_rd;
	logic [HB-1:0]          h_wd, h_rd0, h_rd1;

	logic                   req_acc;
	logic [CW-1:0]          n_act;
	logic [MAX_NODES-1:0]   act_mask;
	logic [NB-1:0]          i_idx, s_idx, cur_idx, src_idx, dst_idx;
	logic                   link_ok, q_bad, cand, clr_last;
	logic [SW-1:0]          run_sum;
	logic [SW-1:0]          thr;
	logic [RANDOM_BITS-1:0] rnd;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// nodes in use, clipped to the table size
	assign n_act = (int'(node_count_q) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count_q);
	always_comb begin
		for (int k = 0; k < MAX_NODES; k++) begin
			act_mask[k] = (k < int'(n_act));
		end
	end

	assign i_idx    = i_q[NB-1:0];
	assign s_idx    = s_q[NB-1:0];
	assign cur_idx  = NB'(req_q.current_node);
	assign src_idx  = NB'(req_q.source_node);
	assign dst_idx  = NB'(req_q.dest_node);
	assign link_ok  = (int'(req.link_from) < MAX_NODES) && (int'(req.link_to) < MAX_NODES);
	assign q_bad    = (int'(req_q.current_node) >= MAX_NODES) ||
	                  (int'(req_q.source_node) >= MAX_NODES) ||
	                  (int'(req_q.dest_node) >= MAX_NODES);
	assign clr_last = &clr_q;
	assign rnd      = RANDOM_BITS'(req_q.random_draw);
	assign thr      = acc_q[PW-1:RANDOM_BITS];

	// candidate test on the hop data read for node i
	assign cand    = (h_rd0 < cd_q) || ((h_rd0 == cd_q) && (h_rd1 < cs_q));
	assign run_sum = run_q + (cand ? SW'(w_rd) : SW'(0));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		w_we  = 1'b0;
		w_wa  = '0;
		w_wd  = '0;
		w_ra  = '0;
		h_we  = 1'b0;
		h_wa  = '0;
		h_wd  = '0;
		h_ra0 = '0;
		h_ra1 = '0;
		case (state_q)
			ST_INIT: begin
				w_we = 1'b1;
				w_wa = clr_q;
				h_we = 1'b1;
				h_wa = clr_q;
				h_wd = (clr_q[AW-1:NB] == clr_q[NB-1:0]) ? HB'(0) : HOP_UNREACH;
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_acc) begin
					case (req.mode)
						MODE_WRITE: begin
							w_we    = link_ok;
							w_wa    = {NB'(req.link_from), NB'(req.link_to)};
							w_wd    = req.link_present ? WEIGHT_BITS'(req.link_weight) : '0;
							state_d = ST_DONE;
						end
						MODE_REBUILD: state_d = ST_RCLR;
						MODE_QUERY:   state_d = ST_QRD;
						default:      state_d = ST_DONE;
					endcase
				end
			end
			ST_RCLR: begin
				h_we = 1'b1;
				h_wa = clr_q;
				h_wd = (clr_q[AW-1:NB] == clr_q[NB-1:0]) ? HB'(0) : HOP_UNREACH;
				if (clr_last) state_d = (n_act == '0) ? ST_DONE : ST_RINIT;
			end
			ST_RINIT: state_d = ST_RSCAN;
			ST_RSCAN: begin
				if (i_q == n_act) state_d = ST_RWR;
			end
			ST_RWR: begin
				if (i_q < n_act) begin
					h_we = nxt_q[i_idx];
					h_wa = {s_idx, i_idx};
					h_wd = lvl_q + HB'(1);
				end else if (nxt_q == '0) begin
					state_d = (s_q + CW'(1) == n_act) ? ST_DONE : ST_RINIT;
				end else begin
					state_d = ST_RSCAN;
				end
			end
			ST_QRD: begin
				w_ra  = {cur_idx, dst_idx};
				h_ra0 = {cur_idx, dst_idx};
				h_ra1 = {cur_idx, src_idx};
				state_d = q_bad ? ST_DONE : ST_QCHK;
			end
			ST_QCHK: state_d = (w_rd != '0) ? ST_DONE : ST_S1I;
			ST_S1I: begin
				w_ra  = {cur_idx, i_idx};
				h_ra0 = {i_idx, dst_idx};
				h_ra1 = {i_idx, src_idx};
				if (i_q < n_act) state_d = ST_S1C;
				else state_d = found_q ? ST_MUL : ST_DONE;
			end
			ST_S1C: state_d = ST_S1I;
			ST_MUL: begin
				if (cnt_q == RCW'(RANDOM_BITS - 1)) state_d = ST_S2I;
			end
			ST_S2I: begin
				w_ra  = {cur_idx, i_idx};
				h_ra0 = {i_idx, dst_idx};
				h_ra1 = {i_idx, src_idx};
				state_d = (i_q < n_act) ? ST_S2C : ST_DONE;
			end
			ST_S2C: state_d = (cand && (run_sum > thr)) ? ST_DONE : ST_S2I;
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// weight memory
	always_ff @(posedge clk) begin
		if (w_we) w_mem[w_wa] <= w_wd;
		w_rd <= w_mem[w_ra];
	end

	// hop-distance memory, two read ports
	always_ff @(posedge clk) begin
		if (h_we) h_mem[h_wa] <= h_wd;
		h_rd0 <= h_mem[h_ra0];
		h_rd1 <= h_mem[h_ra1];
	end

	// configuration and link map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			for (int k = 0; k < MAX_NODES; k++) link_map_q[k] <= '0;
		end else begin
			if (cfg_valid) node_count_q <= cfg_data;
			if (state_q == ST_IDLE && req_acc && req.mode == MODE_WRITE && link_ok) begin
				link_map_q[NB'(req.link_from)][NB'(req.link_to)] <= req.link_present;
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_INIT || state_q == ST_RCLR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) rsp_q <= res_q;
	end

	// shared datapath: frontier unit, adder and shift-add multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					req_q <= req;
					res_q <= '0;
				end
			end
			ST_RCLR: s_q <= '0;
			ST_RINIT: begin
				seen_q  <= MAX_NODES'(1) << s_idx;
				front_q <= MAX_NODES'(1) << s_idx;
				nxt_q   <= '0;
				lvl_q   <= '0;
				i_q     <= '0;
			end
			ST_RSCAN: begin
				if (i_q < n_act) begin
					if (front_q[i_idx]) nxt_q <= nxt_q | (link_map_q[i_idx] & act_mask & ~seen_q);
					i_q <= i_q + CW'(1);
				end else begin
					seen_q <= seen_q | nxt_q;
					i_q    <= '0;
				end
			end
			ST_RWR: begin
				if (i_q < n_act) begin
					i_q <= i_q + CW'(1);
				end else if (nxt_q == '0) begin
					s_q <= s_q + CW'(1);
				end else begin
					front_q <= nxt_q;
					nxt_q   <= '0;
					lvl_q   <= lvl_q + HB'(1);
					i_q     <= '0;
				end
			end
			ST_QCHK: begin
				if (w_rd != '0) begin
					res_q.next_hop      <= req_q.dest_node;
					res_q.has_candidate <= 1'b1;
					res_q.direct_hop    <= 1'b1;
				end
				cd_q    <= h_rd0;
				cs_q    <= h_rd1;
				i_q     <= '0;
				sum_q   <= '0;
				found_q <= 1'b0;
			end
			ST_S1I: begin
				acc_q <= '0;
				cnt_q <= '0;
			end
			ST_S1C: begin
				if (cand) begin
					sum_q <= sum_q + SW'(w_rd);
					if (!found_q) begin
						found_q <= 1'b1;
						first_q <= i_idx;
					end
				end
				i_q <= i_q + CW'(1);
			end
			ST_MUL: begin
				acc_q <= {acc_q[PW-2:0], 1'b0} +
				         (rnd[RCW'(RANDOM_BITS - 1) - cnt_q] ? PW'(sum_q) : PW'(0));
				cnt_q <= cnt_q + RCW'(1);
				i_q   <= '0;
				run_q <= '0;
			end
			ST_S2I: begin
				if (i_q >= n_act) begin
					res_q.next_hop      <= 4'(first_q);
					res_q.has_candidate <= 1'b1;
				end
			end
			ST_S2C: begin
				run_q <= run_sum;
				if (cand && (run_sum > thr)) begin
					res_q.next_hop      <= 4'(i_idx);
					res_q.has_candidate <= 1'b1;
				end
				i_q <= i_q + CW'(1);
			end
			default: ;
		endcase
	end

	// a direct hop always counts as a candidate
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.direct_hop |-> rsp.has_candidate)
		else $error("direct hop without candidate flag");

	// a result without a candidate carries node zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_candidate |-> rsp.next_hop == 4'd0)
		else $error("next hop set without a candidate");

	// an accepted beat blocks the next one while it is at work
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while busy");

endmodule
